[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define VEF_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define VEF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/vef_pkg.sv]
// shared types, constants and register codes of the variometer filter
package vef_pkg;

	localparam int WINDOW_DEF          = 5;
	localparam int PRESSURE_BITS_DEF   = 21;
	localparam int ALPHA_FRAC_BITS_DEF = 16;

	localparam int ALPHA_W     = 16;
	localparam int SLACK_W     = 7;
	localparam int BIAS_W      = 8;
	localparam int START_W     = 21;
	localparam int CFG_DATA_W  = 21;
	localparam int CFG_INDEX_W = 3;
	localparam int RATE_W      = 16;
	localparam int BEEP_W      = 6;

	localparam logic [BEEP_W-1:0] BEEP_CAP = 6'd50;

	localparam logic [ALPHA_W-1:0]        ALPHA_RST      = 16'd6554;
	localparam logic [SLACK_W-1:0]        SLACK_RST      = 7'd10;
	localparam logic signed [BIAS_W-1:0]  SINK_BIAS_RST  = 8'sd0;
	localparam logic signed [BIAS_W-1:0]  RISE_RST       = 8'sd5;
	localparam logic [START_W-1:0]        START_RST      = 21'd1013250;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ALPHA,
		REG_SLACK_BAND,
		REG_SINK_BIAS,
		REG_RISE_THRESHOLD,
		REG_START_VALUE
	} cfg_reg_t;

	typedef struct packed {
		logic [ALPHA_W-1:0]       alpha;
		logic [SLACK_W-1:0]       slack_band;
		logic signed [BIAS_W-1:0] sink_bias;
		logic signed [BIAS_W-1:0] rise_threshold;
	} cfg_t;

	typedef logic signed [1:0] score_t;

	localparam score_t SCORE_UP   = 2'b01;
	localparam score_t SCORE_FLAT = 2'b00;
	localparam score_t SCORE_DOWN = 2'b11;

endpackage

[src/vef_ifs.sv]
// sample and result channel interfaces
interface vef_sample_if #(
	parameter int PRESSURE_BITS = vef_pkg::PRESSURE_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [PRESSURE_BITS-1:0] pressure;

	modport source (output valid, output pressure, input ready);
	modport sink (input valid, input pressure, output ready);
endinterface

interface vef_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [vef_pkg::RATE_W-1:0]  vertical_rate;
	logic [vef_pkg::BEEP_W-1:0]         beep_level;

	modport source (output valid, output vertical_rate, output beep_level, input ready);
	modport sink (input valid, input vertical_rate, input beep_level, output ready);
endinterface

[src/vef_ewma.sv]
// ewma with stiction deadband, score and delta histories, running window sum
module vef_ewma #(
	parameter int WINDOW          = vef_pkg::WINDOW_DEF,
	parameter int PRESSURE_BITS   = vef_pkg::PRESSURE_BITS_DEF,
	parameter int ALPHA_FRAC_BITS = vef_pkg::ALPHA_FRAC_BITS_DEF,
	localparam int DSUM_W         = PRESSURE_BITS + 1 + $clog2(WINDOW)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  vef_pkg::cfg_t            cfg,
	input  logic [PRESSURE_BITS-1:0] start_value,
	input  logic                     reseed,
	input  logic                     step,
	input  logic [PRESSURE_BITS-1:0] pressure,
	output logic signed [DSUM_W-1:0] dsum
);
	localparam int P      = PRESSURE_BITS;
	localparam int F      = ALPHA_FRAC_BITS;
	localparam int HIST   = WINDOW - 1;
	localparam int ACC_W  = P + F;
	localparam int DIFF_W = P + 3;
	localparam int D_W    = P + 1;
	localparam logic [F:0]   ONE       = {1'b1, {F{1'b0}}};
	localparam logic [P-1:0] START_RST = P'(vef_pkg::START_RST);

	logic [ACC_W-1:0]         acc_q;
	logic [P-1:0]             prev_q;
	vef_pkg::score_t          score_q [HIST];
	logic signed [D_W-1:0]    delta_q [HIST];
	logic signed [DSUM_W-1:0] run_q;

	logic [P-1:0]              ewma;
	logic signed [DIFF_W-1:0]  ewma_s, x_s, diff, slack_s, lo, hi, xc;
	vef_pkg::score_t           score;
	logic                      all_up, all_dn;
	logic [P-1:0]              x_u;
	logic [F:0]                a, b;
	logic [P+F:0]              xa, acc_sum;
	logic [ACC_W+F:0]          accb;
	logic [ACC_W-1:0]          acc_nxt;
	logic [P-1:0]              cur;
	logic signed [D_W-1:0]     delta;
	logic signed [DSUM_W-1:0]  run_nxt;

	always_comb begin
		ewma    = acc_q[ACC_W-1:F];
		ewma_s  = signed'(DIFF_W'(ewma));
		x_s     = signed'(DIFF_W'(pressure));
		slack_s = signed'(DIFF_W'(cfg.slack_band));
		diff    = x_s - DIFF_W'(cfg.sink_bias) - ewma_s;

		if (diff > slack_s) begin
			score = vef_pkg::SCORE_UP;
		end else if (diff < -slack_s) begin
			score = vef_pkg::SCORE_DOWN;
		end else begin
			score = vef_pkg::SCORE_FLAT;
		end

		all_up = (score == vef_pkg::SCORE_UP);
		all_dn = (score == vef_pkg::SCORE_DOWN);
		for (int i = 0; i < HIST; i++) begin
			all_up = all_up && (score_q[i] == vef_pkg::SCORE_UP);
			all_dn = all_dn && (score_q[i] == vef_pkg::SCORE_DOWN);
		end

		// clamp into the deadband unless the whole window agrees
		lo = ewma_s - slack_s;
		hi = ewma_s + slack_s;
		xc = x_s;
		if (!(all_up || all_dn)) begin
			if (xc < lo) begin
				xc = lo;
			end
			if (xc > hi) begin
				xc = hi;
			end
		end
		if (xc < 0) begin
			xc = '0;
		end
		x_u = xc[P-1:0];

		a = (32'(cfg.alpha) > 32'(ONE)) ? ONE : (F+1)'(cfg.alpha);
		b = ONE - a;

		xa      = (P+F+1)'(x_u) * (P+F+1)'(a);
		accb    = (ACC_W+F+1)'(acc_q) * (ACC_W+F+1)'(b);
		acc_sum = xa + (P+F+1)'(accb >> F);
		acc_nxt = acc_sum[ACC_W-1:0];

		cur     = acc_nxt[ACC_W-1:F];
		delta   = signed'(D_W'(cur)) - signed'(D_W'(prev_q));
		dsum    = run_q + DSUM_W'(delta);
		run_nxt = dsum - DSUM_W'(delta_q[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= {START_RST, {F{1'b0}}};
			prev_q <= START_RST;
			run_q  <= '0;
			for (int i = 0; i < HIST; i++) begin
				score_q[i] <= vef_pkg::SCORE_FLAT;
				delta_q[i] <= '0;
			end
		end else if (reseed) begin
			acc_q  <= {start_value, {F{1'b0}}};
			prev_q <= start_value;
			run_q  <= '0;
			for (int i = 0; i < HIST; i++) begin
				score_q[i] <= vef_pkg::SCORE_FLAT;
				delta_q[i] <= '0;
			end
		end else if (step) begin
			acc_q  <= acc_nxt;
			prev_q <= cur;
			run_q  <= run_nxt;
			for (int i = 0; i < HIST - 1; i++) begin
				score_q[i] <= score_q[i+1];
				delta_q[i] <= delta_q[i+1];
			end
			score_q[HIST-1] <= score;
			delta_q[HIST-1] <= delta;
		end
	end

endmodule

[src/vef_rate.sv]
// window average by reciprocal multiply, rate saturation and beep level
module vef_rate #(
	parameter int WINDOW          = vef_pkg::WINDOW_DEF,
	parameter int PRESSURE_BITS   = vef_pkg::PRESSURE_BITS_DEF,
	localparam int DSUM_W         = PRESSURE_BITS + 1 + $clog2(WINDOW)
) (
	input  logic                              clk,
	input  logic                              load,
	input  logic signed [DSUM_W-1:0]          dsum,
	input  vef_pkg::cfg_t                     cfg,
	output logic signed [vef_pkg::RATE_W-1:0] vertical_rate,
	output logic [vef_pkg::BEEP_W-1:0]        beep_level
);
	localparam int M_W    = DSUM_W;
	localparam int S      = M_W;
	localparam int R_W    = M_W + 2;
	localparam int RATE_W = vef_pkg::RATE_W;
	localparam logic [63:0]            RECIP64  = (64'd1 << S) / 64'(WINDOW);
	localparam logic [M_W-1:0]         RECIP    = RECIP64[M_W-1:0];
	localparam logic [M_W-1:0]         WIN_M    = M_W'(WINDOW);
	localparam logic signed [R_W-1:0]  RATE_MAX = R_W'(32767);
	localparam logic signed [R_W-1:0]  RATE_MIN = -R_W'(32768);

	logic                 neg;
	logic [M_W-1:0]       mag;
	logic [2*M_W-1:0]     prod;
	logic                 neg_s3;
	logic [M_W-1:0]       mag_s3, q0_s3;

	logic [M_W-1:0]            qw, rem, q;
	logic signed [R_W-1:0]     rate_w;
	logic signed [RATE_W-1:0]  rate16, rise16, cap16;

	always_comb begin
		neg  = dsum[DSUM_W-1];
		mag  = M_W'(neg ? -dsum : dsum);
		prod = (2*M_W)'(mag) * (2*M_W)'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_s3 <= neg;
			mag_s3 <= mag;
			q0_s3  <= prod[2*M_W-1:S];
		end
	end

	// estimate is low by at most one
	always_comb begin
		qw  = M_W'(q0_s3 * WIN_M);
		rem = mag_s3 - qw;
		q   = q0_s3 + M_W'(rem >= WIN_M);

		rate_w = neg_s3 ? signed'(R_W'(q)) : -signed'(R_W'(q));
		rate_w = rate_w + R_W'(cfg.sink_bias);
		if (rate_w > RATE_MAX) begin
			rate_w = RATE_MAX;
		end
		if (rate_w < RATE_MIN) begin
			rate_w = RATE_MIN;
		end
		rate16 = rate_w[RATE_W-1:0];

		rise16 = RATE_W'(cfg.rise_threshold);
		cap16  = signed'(RATE_W'(vef_pkg::BEEP_CAP));
		if (rate16 < rise16 || rate16 < 0) begin
			beep_level = '0;
		end else if (rate16 > cap16) begin
			beep_level = vef_pkg::BEEP_CAP;
		end else begin
			beep_level = rate16[vef_pkg::BEEP_W-1:0];
		end
		vertical_rate = rate16;
	end

endmodule

[src/variometer_ewma_stiction_filter_core.sv]
// Variometer filter: one pressure sample in, one vertical rate and beep level out. The
// block takes a sample every cycle while it is not held off and passes it through the
// input register, ewma update, window divide and result register; stalls on the result
// side fill the stages in turn and only then hold off new samples. The clock is set by
// the ewma update, two multiplies and an add, because each sample needs the accumulator
// left by the one before. Configuration is written through cfg_we, cfg_index and
// cfg_wdata, by the user only while no sample is in flight (not enforced by the block);
// a write to start_value reseeds the filter and clears the score and delta histories.
module variometer_ewma_stiction_filter_core #(
	parameter int WINDOW          = vef_pkg::WINDOW_DEF,
	parameter int PRESSURE_BITS   = vef_pkg::PRESSURE_BITS_DEF,
	parameter int ALPHA_FRAC_BITS = vef_pkg::ALPHA_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	vef_sample_if.sink                         sample,
	vef_result_if.source                       result,
	input  logic                               cfg_we,
	input  logic [vef_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [vef_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	localparam int P      = PRESSURE_BITS;
	localparam int DSUM_W = PRESSURE_BITS + 1 + $clog2(WINDOW);

	logic [vef_pkg::ALPHA_W-1:0]       alpha_q;
	logic [vef_pkg::SLACK_W-1:0]       slack_band_q;
	logic signed [vef_pkg::BIAS_W-1:0] sink_bias_q;
	logic signed [vef_pkg::BIAS_W-1:0] rise_threshold_q;
	vef_pkg::cfg_t                     cfg;
	logic [63:0]                       cfg_ext;
	logic                              reseed;

	logic                              valid_s1, valid_s2, valid_s3, valid_s4;
	logic                              en_s1, en_s2, en_s3, en_s4;
	logic [P-1:0]                      pressure_s1;
	logic signed [DSUM_W-1:0]          dsum, dsum_s2;
	logic signed [vef_pkg::RATE_W-1:0] rate;
	logic [vef_pkg::BEEP_W-1:0]        beep;
	logic signed [vef_pkg::RATE_W-1:0] rate_s4;
	logic [vef_pkg::BEEP_W-1:0]        beep_s4;

	assign cfg_ext = 64'(cfg_wdata);
	assign reseed  = cfg_we && (vef_pkg::cfg_reg_t'(cfg_index) == vef_pkg::REG_START_VALUE);
	assign cfg     = '{alpha: alpha_q, slack_band: slack_band_q,
		sink_bias: sink_bias_q, rise_threshold: rise_threshold_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q          <= vef_pkg::ALPHA_RST;
			slack_band_q     <= vef_pkg::SLACK_RST;
			sink_bias_q      <= vef_pkg::SINK_BIAS_RST;
			rise_threshold_q <= vef_pkg::RISE_RST;
		end else if (cfg_we) begin
			unique case (vef_pkg::cfg_reg_t'(cfg_index))
				vef_pkg::REG_ALPHA:          alpha_q          <= cfg_wdata[vef_pkg::ALPHA_W-1:0];
				vef_pkg::REG_SLACK_BAND:     slack_band_q     <= cfg_wdata[vef_pkg::SLACK_W-1:0];
				vef_pkg::REG_SINK_BIAS:      sink_bias_q      <= cfg_wdata[vef_pkg::BIAS_W-1:0];
				vef_pkg::REG_RISE_THRESHOLD: rise_threshold_q <= cfg_wdata[vef_pkg::BIAS_W-1:0];
				vef_pkg::REG_START_VALUE:    ;
				default: ;
			endcase
		end
	end

	// each stage moves when empty or when the next one moves
	assign en_s4        = !valid_s4 || result.ready;
	assign en_s3        = !valid_s3 || en_s4;
	assign en_s2        = !valid_s2 || en_s3;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= sample.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && sample.valid) begin
			pressure_s1 <= sample.pressure;
		end
		if (valid_s1 && en_s2) begin
			dsum_s2 <= dsum;
		end
		if (valid_s3 && en_s4) begin
			rate_s4 <= rate;
			beep_s4 <= beep;
		end
	end

	vef_ewma #(
		.WINDOW          (WINDOW),
		.PRESSURE_BITS   (PRESSURE_BITS),
		.ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
	) u_ewma (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.start_value (cfg_ext[P-1:0]),
		.reseed      (reseed),
		.step        (valid_s1 && en_s2),
		.pressure    (pressure_s1),
		.dsum        (dsum)
	);

	vef_rate #(
		.WINDOW        (WINDOW),
		.PRESSURE_BITS (PRESSURE_BITS)
	) u_rate (
		.clk           (clk),
		.load          (valid_s2 && en_s3),
		.dsum          (dsum_s2),
		.cfg           (cfg),
		.vertical_rate (rate),
		.beep_level    (beep)
	);

	assign result.valid         = valid_s4;
	assign result.vertical_rate = rate_s4;
	assign result.beep_level    = beep_s4;

endmodule

[src/vef_checker.sv]
// port-level checks on the variometer filter, bound to the top level
`include "assert_macros.svh"

module vef_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               sample_valid,
	input logic                               sample_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic signed [vef_pkg::RATE_W-1:0]  vertical_rate,
	input logic [vef_pkg::BEEP_W-1:0]         beep_level
);
	localparam int LATENCY = 4;
	localparam logic [vef_pkg::BEEP_W-1:0]        CAP      = vef_pkg::BEEP_CAP;
	localparam logic signed [vef_pkg::RATE_W-1:0] CAP_RATE = signed'(vef_pkg::RATE_W'(CAP));

	`VEF_ASSERT_IMPLY(a_beep_cap, result_valid, beep_level <= CAP, "beep level above cap")

	`VEF_ASSERT_IMPLY(a_beep_follows_rate, result_valid && beep_level != '0, !vertical_rate[vef_pkg::RATE_W-1] && ((vertical_rate > CAP_RATE && beep_level == CAP) || (vertical_rate <= CAP_RATE && vertical_rate[vef_pkg::BEEP_W-1:0] == beep_level)), "beep level does not match rate")

	`VEF_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(vertical_rate) && $stable(beep_level), "stalled result changed")

	`VEF_ASSERT_IMPLY(a_result_from_transfer, $rose(result_valid), $past(sample_valid && sample_ready, LATENCY), "result without earlier sample transfer")

endmodule

bind variometer_ewma_stiction_filter_core vef_checker u_vef_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.sample_valid  (sample.valid),
	.sample_ready  (sample.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.vertical_rate (result.vertical_rate),
	.beep_level    (result.beep_level)
);

[tb/sv/variometer_ewma_stiction_filter_core_tb.sv]
// testbench of the variometer filter core: directed table, then random pressure walks
`timescale 1ns / 100ps

module variometer_ewma_stiction_filter_core_tb;
	import vef_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 10;
	localparam int HOLD_CYCLES  = 64;
	localparam int HOLD_SPACING = 900;
	localparam int BLOCK_ITEMS  = 97;
	localparam int BLOCKS       = 6;

	localparam int HIST    = WINDOW_DEF - 1;
	localparam int ACC_W   = PRESSURE_BITS_DEF + ALPHA_FRAC_BITS_DEF;
	localparam int DELTA_W = PRESSURE_BITS_DEF + 1;
	localparam longint ONE = longint'(1) << ALPHA_FRAC_BITS_DEF;

	localparam logic [START_W-1:0]        P_MAX    = '1;
	localparam int                        P_MAX_I  = (1 << START_W) - 1;
	localparam logic signed [RATE_W-1:0]  RATE_MAX = 16'sh7fff;
	localparam logic signed [RATE_W-1:0]  RATE_MIN = 16'sh8000;

	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = CFG_INDEX_W'(REG_START_VALUE + 1);
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = '1;

	typedef struct packed {
		logic signed [RATE_W-1:0] vertical_rate;
		logic [BEEP_W-1:0]        beep_level;
	} rate_beep_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_INDEX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]    data;
		bit                       checked;
		logic signed [RATE_W-1:0] rate;
		logic [BEEP_W-1:0]        beep;
	} directed_row_t;

	localparam int NUM_DIRECTED = 41;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{ROW_SAMPLE, '0, START_RST, 1, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, P_MAX, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd1013300, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_START_VALUE, 21'd1000000, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_ALPHA, 21'h1f0000, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_SINK_BIAS, 21'h000080, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd1000000, 1, -16'sd128, 6'd0},
		'{ROW_WRITE, REG_SINK_BIAS, 21'h1fff7f, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_RISE_THRESHOLD, 21'h000080, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd5, 1, 16'sd127, 6'd50},
		'{ROW_WRITE, REG_SINK_BIAS, 21'd30, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_RISE_THRESHOLD, 21'd30, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, P_MAX, 1, 16'sd30, 6'd30},
		'{ROW_WRITE, REG_RISE_THRESHOLD, 21'd31, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd123, 1, 16'sd30, 6'd0},
		'{ROW_WRITE, REG_SINK_BIAS, 21'h0000fd, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_RISE_THRESHOLD, 21'h1ffffb, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd999999, 1, -16'sd3, 6'd0},
		'{ROW_WRITE, REG_UNMAPPED_LO, 21'h1fffff, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_UNMAPPED_HI, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd1000001, 1, -16'sd3, 6'd0},
		'{ROW_WRITE, REG_START_VALUE, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_ALPHA, 21'd65535, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_SLACK_BAND, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_SINK_BIAS, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, P_MAX, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, P_MAX, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, P_MAX, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, P_MAX, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, P_MAX, 1, RATE_MIN, 6'd0},
		'{ROW_WRITE, REG_START_VALUE, P_MAX, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd0, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd0, 1, RATE_MAX, 6'd50},
		'{ROW_WRITE, REG_SLACK_BAND, 21'h1fffff, 0, 16'sd0, 6'd0},
		'{ROW_WRITE, REG_ALPHA, 21'd32768, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd1500000, 0, 16'sd0, 6'd0},
		'{ROW_SAMPLE, '0, 21'd40, 0, 16'sd0, 6'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	vef_sample_if sample_ch ();
	vef_result_if result_ch ();

	variometer_ewma_stiction_filter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// filter copy kept alongside the block
	logic [ALPHA_W-1:0]          fl_alpha;
	logic [SLACK_W-1:0]          fl_slack;
	logic signed [BIAS_W-1:0]    fl_bias;
	logic signed [BIAS_W-1:0]    fl_rise;
	logic [START_W-1:0]          fl_start;
	logic [ACC_W-1:0]            fl_acc;
	logic [START_W-1:0]          fl_prev_out;
	score_t                      fl_scores [HIST];
	logic signed [DELTA_W-1:0]   fl_deltas [HIST];

	rate_beep_t expected_rates [$];
	rate_beep_t want;

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int unmapped_writes = 0;
	int mismatches = 0;
	int saturated = 0;
	int beeps = 0;
	int long_holds = 0;
	int next_hold_at = 400;
	int walk = 0;

	function automatic void reseed_filter();
		fl_acc = {fl_start, {ALPHA_FRAC_BITS_DEF{1'b0}}};
		fl_prev_out = fl_start;
		for (int i = 0; i < HIST; i++) begin
			fl_scores[i] = SCORE_FLAT;
			fl_deltas[i] = '0;
		end
	endfunction

	function automatic void store_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ALPHA: fl_alpha = data[ALPHA_W-1:0];
			REG_SLACK_BAND: fl_slack = data[SLACK_W-1:0];
			REG_SINK_BIAS: fl_bias = data[BIAS_W-1:0];
			REG_RISE_THRESHOLD: fl_rise = data[BIAS_W-1:0];
			REG_START_VALUE: begin
				fl_start = data[START_W-1:0];
				reseed_filter();
			end
			default: ;
		endcase
	endfunction

	function automatic rate_beep_t filter_sample(input logic [START_W-1:0] pressure);
		longint x, ewma, diff, slack, bias, a, b, fr, acc_next, cur, delta, dsum, rate;
		int score_sum;
		score_t score;
		rate_beep_t r;
		x = longint'(pressure);
		ewma = longint'(fl_acc >> ALPHA_FRAC_BITS_DEF);
		slack = longint'(fl_slack);
		bias = longint'(fl_bias);
		diff = x - bias - ewma;
		if (diff > slack)
			score = SCORE_UP;
		else if (diff < -slack)
			score = SCORE_DOWN;
		else
			score = SCORE_FLAT;
		score_sum = int'(score);
		for (int i = 0; i < HIST; i++)
			score_sum += int'(fl_scores[i]);
		for (int i = 0; i + 1 < HIST; i++)
			fl_scores[i] = fl_scores[i + 1];
		fl_scores[HIST-1] = score;
		// deadband clamp unless the whole window agrees
		if (score_sum != WINDOW_DEF && score_sum != -WINDOW_DEF) begin
			if (x < ewma - slack)
				x = ewma - slack;
			if (x > ewma + slack)
				x = ewma + slack;
		end
		if (x < 0)
			x = 0;
		a = longint'(fl_alpha);
		if (a > ONE)
			a = ONE;
		b = ONE - a;
		fr = longint'(fl_acc[ALPHA_FRAC_BITS_DEF-1:0]);
		acc_next = x * a + ewma * b + ((fr * b) >>> ALPHA_FRAC_BITS_DEF);
		fl_acc = acc_next[ACC_W-1:0];
		cur = acc_next >>> ALPHA_FRAC_BITS_DEF;
		delta = cur - longint'(fl_prev_out);
		fl_prev_out = cur[START_W-1:0];
		dsum = delta;
		for (int i = 0; i < HIST; i++)
			dsum += longint'(fl_deltas[i]);
		for (int i = 0; i + 1 < HIST; i++)
			fl_deltas[i] = fl_deltas[i + 1];
		fl_deltas[HIST-1] = delta[DELTA_W-1:0];
		rate = -(dsum / WINDOW_DEF) + bias;
		if (rate > longint'(RATE_MAX))
			rate = longint'(RATE_MAX);
		if (rate < longint'(RATE_MIN))
			rate = longint'(RATE_MIN);
		r.vertical_rate = rate[RATE_W-1:0];
		if (rate < longint'(fl_rise) || rate < 0)
			r.beep_level = '0;
		else if (rate > longint'(BEEP_CAP))
			r.beep_level = BEEP_CAP;
		else
			r.beep_level = rate[BEEP_W-1:0];
		return r;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("ERROR: %s", msg);
	endtask

	task automatic send_sample(input logic [START_W-1:0] p, input bit typed,
			input rate_beep_t typed_val);
		rate_beep_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.pressure <= p;
		do @(posedge clk); while (!sample_ch.ready);
		predicted = filter_sample(p);
		expected_rates.push_back(typed ? typed_val : predicted);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (expected_rates.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		store_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		reg_writes++;
		if (idx > REG_START_VALUE)
			unmapped_writes++;
	endtask

	task automatic run_random_block(input int n);
		logic [CFG_DATA_W-1:0] wd;
		logic [START_W-1:0] p;
		int slope, amp, v;
		drain_results();
		wd = CFG_DATA_W'($urandom);
		case ($urandom_range(4))
			0: wd[ALPHA_W-1:0] = '0;
			1: wd[ALPHA_W-1:0] = '1;
			2: wd[ALPHA_W-1:0] = ALPHA_W'($urandom);
			default: wd[ALPHA_W-1:0] = ALPHA_W'($urandom_range(12000, 300));
		endcase
		write_reg(REG_ALPHA, wd);
		wd = CFG_DATA_W'($urandom);
		case ($urandom_range(3))
			0: wd[SLACK_W-1:0] = '0;
			1: wd[SLACK_W-1:0] = '1;
			default: wd[SLACK_W-1:0] = SLACK_W'($urandom_range(40));
		endcase
		write_reg(REG_SLACK_BAND, wd);
		wd = CFG_DATA_W'($urandom);
		case ($urandom_range(3))
			0: wd[BIAS_W-1:0] = 8'h80;
			1: wd[BIAS_W-1:0] = 8'h7f;
			2: wd[BIAS_W-1:0] = 8'($urandom_range(40)) - 8'd20;
			default: ;
		endcase
		write_reg(REG_SINK_BIAS, wd);
		wd = CFG_DATA_W'($urandom);
		if ($urandom_range(1))
			wd[BIAS_W-1:0] = 8'($urandom_range(70)) - 8'd10;
		write_reg(REG_RISE_THRESHOLD, wd);
		if ($urandom_range(1)) begin
			wd = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
				: CFG_DATA_W'($urandom_range(1100000, 900000));
			write_reg(REG_START_VALUE, wd);
			walk = int'(wd);
		end
		if ($urandom_range(7) == 0)
			write_reg(CFG_INDEX_W'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
				CFG_DATA_W'($urandom));
		slope = int'($urandom_range(400)) - 200;
		amp = $urandom_range(30);
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 31)
				slope = -slope;
			v = $urandom_range(99);
			if (v < 4) begin
				p = START_W'($urandom);
			end else if (v < 6) begin
				p = (v == 4) ? '0 : P_MAX;
			end else begin
				walk += slope + int'($urandom_range(2 * amp)) - amp;
				if (walk < 0)
					walk = 0;
				if (walk > P_MAX_I)
					walk = P_MAX_I;
				p = walk[START_W-1:0];
			end
			send_sample(p, 1'b0, '0);
		end
	endtask

	// result side: random back-pressure plus an occasional long hold-off
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (results_seen >= next_hold_at) begin
				next_hold_at += HOLD_SPACING;
				long_holds++;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_rates.size() == 0) begin
				flag_error($sformatf(
					"result with nothing pending: vertical_rate %0d beep_level %0d",
					result_ch.vertical_rate, result_ch.beep_level));
			end else begin
				want = expected_rates.pop_front();
				if (result_ch.vertical_rate !== want.vertical_rate
						|| result_ch.beep_level !== want.beep_level)
					flag_error($sformatf(
						"result %0d: vertical_rate exp %0d got %0d, beep_level exp %0d got %0d",
						results_seen, want.vertical_rate, result_ch.vertical_rate,
						want.beep_level, result_ch.beep_level));
				if (want.vertical_rate == RATE_MAX || want.vertical_rate == RATE_MIN)
					saturated++;
				if (want.beep_level != '0)
					beeps++;
			end
			results_seen++;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("variometer_ewma_stiction_filter_core_tb failed");
		$finish;
	end

	initial begin
		rate_beep_t typed_val;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.pressure = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		fl_alpha = ALPHA_RST;
		fl_slack = SLACK_RST;
		fl_bias = SINK_BIAS_RST;
		fl_rise = RISE_RST;
		fl_start = START_RST;
		reseed_filter();
		walk = int'(START_RST);
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 8;
		snk_idle_pct = 72;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_results();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				typed_val.vertical_rate = directed_rows[i].rate;
				typed_val.beep_level = directed_rows[i].beep;
				send_sample(directed_rows[i].data, directed_rows[i].checked, typed_val);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 8;
					snk_idle_pct = 72;
				end
				1: begin
					src_idle_pct = 72;
					snk_idle_pct = 8;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < BLOCKS; blk++)
				run_random_block(BLOCK_ITEMS);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d samples, %0d register writes (%0d unmapped), %0d results checked",
			samples_sent, reg_writes, unmapped_writes, results_seen);
		$display("%0d saturated rates, %0d beeps, %0d long result stalls, %0d mismatches",
			saturated, beeps, long_holds, mismatches);
		if (mismatches == 0)
			$display("variometer_ewma_stiction_filter_core_tb passed");
		else
			$display("variometer_ewma_stiction_filter_core_tb failed");
		$finish;
	end

endmodule
